FILE: hdl/kcrcf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and types of the key color rectangle corner finder.
package kcrcf_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int MAX_RECTS = 16;

    localparam int CW     = 8;
    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int WW     = XW + 1;
    localparam int YW     = 10;
    localparam int RIW    = $clog2(MAX_RECTS);
    localparam int RCW    = $clog2(MAX_RECTS + 1);
    localparam int CFG_IW = 3;
    localparam int CFG_DW = WW;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [CFG_IW-1:0] REG_KEY_BLUE    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_KEY_GREEN   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_KEY_RED     = 3'd2;
    localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH = 3'd3;
    localparam logic [CFG_IW-1:0] REG_SCAN_WIDTH  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_SCAN_HEIGHT = 3'd5;

    localparam logic [CW-1:0] KEY_BLUE_RST    = 8'd76;
    localparam logic [CW-1:0] KEY_GREEN_RST   = 8'd177;
    localparam logic [CW-1:0] KEY_RED_RST     = 8'd34;
    localparam logic [WW-1:0] IMAGE_WIDTH_RST = WW'(640);
    localparam logic [XW-1:0] SCAN_WIDTH_RST  = XW'(150);
    localparam logic [YW-1:0] SCAN_HEIGHT_RST = YW'(70);

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    typedef struct packed {
        logic [CW-1:0] key_blue;
        logic [CW-1:0] key_green;
        logic [CW-1:0] key_red;
        logic [WW-1:0] image_width;
        logic [XW-1:0] scan_width;
        logic [YW-1:0] scan_height;
    } cfg_t;

    typedef struct packed {
        logic          clear;
        logic [1:0]    kind;
        logic [XW-1:0] x;
        logic [YW-1:0] y;
    } cmd_t;

endpackage

FILE: hdl/kcrcf_ifs.sv
`timescale 1ns / 1ps
// Pixel and corner channel interfaces.
interface kcrcf_pixel_if;
    import kcrcf_pkg::*;

    logic          valid;
    logic          ready;
    logic [CW-1:0] blue;
    logic [CW-1:0] green;
    logic [CW-1:0] red;
    logic          frame_start;

    modport source (output valid, output blue, output green, output red,
                    output frame_start, input ready);
    modport sink   (input valid, input blue, input green, input red,
                    input frame_start, output ready);
endinterface

interface kcrcf_corner_if;
    import kcrcf_pkg::*;

    logic           valid;
    logic           ready;
    logic [RIW-1:0] rect_index;
    logic [1:0]     corner_kind;
    logic [XW-1:0]  corner_x;
    logic [YW-1:0]  corner_y;
    logic           error_flag;
    logic           last_of_run;

    modport source (output valid, output rect_index, output corner_kind, output corner_x,
                    output corner_y, output error_flag, output last_of_run, input ready);
    modport sink   (input valid, input rect_index, input corner_kind, input corner_x,
                    input corner_y, input error_flag, input last_of_run, output ready);
endinterface

FILE: hdl/kcrcf_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the classifier and the rectangle table.
module kcrcf_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  kcrcf_pkg::cmd_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output kcrcf_pkg::cmd_t pop_data
);
    import kcrcf_pkg::*;

    cmd_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_next;
    logic [QAW:0]   count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != (QAW+1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? QAW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QAW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = (QAW+1)'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = (QAW+1)'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/kcrcf_front.sv
`timescale 1ns / 1ps
// Pixel front end: raster counters, key flag row memory and corner classification.
module kcrcf_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  kcrcf_pkg::cfg_t cfg,
    kcrcf_pixel_if.sink     pixel,
    output logic            push_valid,
    input  logic            push_ready,
    output kcrcf_pkg::cmd_t push_data
);
    import kcrcf_pkg::*;

    logic [1:0]    flag_mem [MAX_WIDTH];
    logic [1:0]    rd0_reg;
    logic [1:0]    rd1_reg;

    logic [XW-1:0] col_reg;
    logic [YW-1:0] row_reg;
    logic [XW-1:0] col_next;
    logic [YW-1:0] row_next;

    logic          s_valid_reg;
    logic          s_valid_next;
    logic [XW-1:0] s_x_reg;
    logic [YW-1:0] s_cy_reg;
    logic          s_key_reg;
    logic          s_elig_reg;
    logic          s_top_ok_reg;
    logic          s_left_ok_reg;
    logic          s_right_ok_reg;
    logic          s_clear_reg;
    logic          s_fw0_reg;
    logic          s_fw1_reg;
    logic [1:0]    s_fwd_reg;
    logic          last_e0_reg;

    logic [WW-1:0] w;
    logic          key;
    logic          accept;
    logic          advance;
    logic [XW-1:0] x;
    logic [YW-1:0] r;
    logic [YW-1:0] cy;
    logic [WW-1:0] x1_full;
    logic [XW-1:0] x1;

    logic [1:0]    e;
    logic [1:0]    n;
    logic          corner;
    logic          above;
    logic          below;
    logic          left;
    logic          right;
    logic          has_kind;
    logic [1:0]    kind;
    logic          wr_en;
    logic [1:0]    wr_data;

    // effective row width
    always_comb
    begin
        priority if (cfg.image_width == '0)
        begin
            w = WW'(1);
        end
        else if (cfg.image_width > WW'(MAX_WIDTH))
        begin
            w = WW'(MAX_WIDTH);
        end
        else
        begin
            w = cfg.image_width;
        end
    end

    assign key = (pixel.blue == cfg.key_blue) && (pixel.green == cfg.key_green) &&
                 (pixel.red == cfg.key_red);
    assign accept = pixel.valid && pixel.ready;

    always_comb
    begin
        priority if (pixel.frame_start)
        begin
            x = '0;
            r = '0;
        end
        else if ({1'b0, col_reg} >= w)
        begin
            x = '0;
            r = YW'(row_reg + 1'b1);
        end
        else
        begin
            x = col_reg;
            r = row_reg;
        end
        x1_full = WW'({1'b0, x} + 1'b1);
        x1      = x1_full[XW-1:0];
        cy      = YW'(r - 1'b1);
        if (x1_full >= w)
        begin
            col_next = '0;
            row_next = YW'(r + 1'b1);
        end
        else
        begin
            col_next = x1;
            row_next = r;
        end
    end

    // evaluation of the pixel one row up
    assign e = s_fw0_reg ? s_fwd_reg : rd0_reg;
    assign n = s_fw1_reg ? s_fwd_reg : rd1_reg;

    assign corner = s_elig_reg && e[0];
    assign above  = s_top_ok_reg && e[1];
    assign below  = s_key_reg;
    assign left   = s_left_ok_reg && last_e0_reg;
    assign right  = s_right_ok_reg && n[0];

    always_comb
    begin
        has_kind = corner;
        kind     = CORNER_TL;
        priority if (!above && !left)
        begin
            kind = CORNER_TL;
        end
        else if (!above && !right)
        begin
            kind = CORNER_TR;
        end
        else if (!below && !left)
        begin
            kind = CORNER_BL;
        end
        else if (!below && !right)
        begin
            kind = CORNER_BR;
        end
        else
        begin
            has_kind = 1'b0;
        end
    end

    assign push_valid = s_valid_reg && (s_clear_reg || has_kind);
    assign advance    = !push_valid || push_ready;
    assign pixel.ready = advance;

    assign push_data.clear = s_clear_reg;
    assign push_data.kind  = kind;
    assign push_data.x     = s_x_reg;
    assign push_data.y     = s_cy_reg;

    assign wr_en   = s_valid_reg && advance;
    assign wr_data = {e[0], s_key_reg};

    always_comb
    begin
        s_valid_next = s_valid_reg;
        if (accept)
        begin
            s_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            s_valid_reg <= 1'b0;
            last_e0_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (wr_en)
            begin
                last_e0_reg <= e[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_x_reg        <= x;
            s_cy_reg       <= cy;
            s_key_reg      <= key;
            s_elig_reg     <= (r != '0) && (x < cfg.scan_width) && (cy < cfg.scan_height);
            s_top_ok_reg   <= (cy != '0);
            s_left_ok_reg  <= (x != '0);
            s_right_ok_reg <= (x1_full < w);
            s_clear_reg    <= pixel.frame_start;
            // bypass a flag word written at the same edge
            s_fw0_reg      <= wr_en && (s_x_reg == x);
            s_fw1_reg      <= wr_en && (s_x_reg == x1);
            s_fwd_reg      <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            flag_mem[s_x_reg] <= wr_data;
        end
        if (accept)
        begin
            rd0_reg <= flag_mem[x];
            rd1_reg <= flag_mem[x1];
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg && !advance |=> s_valid_reg && $stable(s_x_reg))
        else $error("front stage lost a stalled pixel");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s_valid_reg)
        else $error("accepted pixel did not reach the evaluation stage");

endmodule

FILE: hdl/kcrcf_back.sv
`timescale 1ns / 1ps
// Rectangle table: applies classified corners and drives the result register.
module kcrcf_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  kcrcf_pkg::cmd_t cmd_data,
    kcrcf_corner_if.source  corner
);
    import kcrcf_pkg::*;

    logic [XW-1:0]        edge_x_reg [MAX_RECTS];
    logic [MAX_RECTS-1:0] edge_valid_reg;
    logic [MAX_RECTS-1:0] edge_valid_next;
    logic [RCW-1:0]       rect_count_reg;
    logic [RCW-1:0]       rect_count_next;
    logic [RIW-1:0]       cur_reg;
    logic [RIW-1:0]       cur_next;
    logic [MAX_RECTS-1:0] mask_reg;
    logic [MAX_RECTS-1:0] mask_next;
    logic [XW-1:0]        bl_x_reg;
    logic [YW-1:0]        bl_y_reg;

    logic                 o_valid_reg;
    logic [RIW-1:0]       o_idx_reg;
    logic [1:0]           o_kind_reg;
    logic [XW-1:0]        o_x_reg;
    logic [YW-1:0]        o_y_reg;
    logic                 o_err_reg;
    logic                 o_last_reg;

    logic                 out_free;
    logic                 draining;
    logic                 pop;
    logic [MAX_RECTS-1:0] match;
    logic [RIW-1:0]       match_hi;
    logic [RIW-1:0]       low_idx;
    logic [MAX_RECTS-1:0] low_onehot;
    logic [MAX_RECTS-1:0] rest;
    logic [RIW-1:0]       count_idx;
    logic                 full;

    logic                 load;
    logic [RIW-1:0]       n_idx;
    logic [1:0]           n_kind;
    logic [XW-1:0]        n_x;
    logic [YW-1:0]        n_y;
    logic                 n_err;
    logic                 n_last;
    logic                 edge_we;
    logic                 bl_we;

    assign out_free  = !o_valid_reg || corner.ready;
    assign draining  = (mask_reg != '0);
    assign cmd_ready = out_free && !draining;
    assign pop       = cmd_valid && cmd_ready;
    assign count_idx = rect_count_reg[RIW-1:0];
    assign full      = (rect_count_reg >= RCW'(MAX_RECTS));

    assign low_onehot = mask_reg & (~mask_reg + 1'b1);
    assign rest       = mask_reg & ~low_onehot;

    always_comb
    begin
        match_hi = '0;
        low_idx  = '0;
        for (int i = 0; i < MAX_RECTS; i++)
        begin
            match[i] = edge_valid_reg[i] && (edge_x_reg[i] == cmd_data.x);
            if (match[i])
            begin
                match_hi = RIW'(i);
            end
        end
        for (int i = MAX_RECTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                low_idx = RIW'(i);
            end
        end
    end

    always_comb
    begin
        edge_valid_next = edge_valid_reg;
        rect_count_next = rect_count_reg;
        cur_next        = cur_reg;
        mask_next       = mask_reg;
        edge_we         = 1'b0;
        bl_we           = 1'b0;
        load            = 1'b0;
        n_idx           = '0;
        n_kind          = cmd_data.kind;
        n_x             = cmd_data.x;
        n_y             = cmd_data.y;
        n_err           = 1'b0;
        n_last          = 1'b1;
        if (draining)
        begin
            if (out_free)
            begin
                load      = 1'b1;
                n_idx     = low_idx;
                n_kind    = CORNER_BL;
                n_x       = bl_x_reg;
                n_y       = bl_y_reg;
                n_last    = (rest == '0);
                mask_next = rest;
            end
        end
        else if (pop)
        begin
            if (cmd_data.clear)
            begin
                edge_valid_next = '0;
                rect_count_next = '0;
                cur_next        = '0;
            end
            else
            begin
                unique case (cmd_data.kind)
                    CORNER_TL:
                    begin
                        load = 1'b1;
                        if (full)
                        begin
                            n_err = 1'b1;
                        end
                        else
                        begin
                            edge_we                    = 1'b1;
                            edge_valid_next[count_idx] = 1'b1;
                            cur_next                   = count_idx;
                            rect_count_next            = RCW'(rect_count_reg + 1'b1);
                            n_idx                      = count_idx;
                        end
                    end
                    CORNER_TR, CORNER_BR:
                    begin
                        load = 1'b1;
                        if (rect_count_reg == '0)
                        begin
                            n_err = 1'b1;
                        end
                        else
                        begin
                            n_idx = cur_reg;
                        end
                    end
                    CORNER_BL:
                    begin
                        edge_valid_next = edge_valid_reg & ~match;
                        mask_next       = match;
                        bl_we           = 1'b1;
                        if (match != '0)
                        begin
                            cur_next = match_hi;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_valid_reg <= '0;
            rect_count_reg <= '0;
            cur_reg        <= '0;
            mask_reg       <= '0;
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            edge_valid_reg <= edge_valid_next;
            rect_count_reg <= rect_count_next;
            cur_reg        <= cur_next;
            mask_reg       <= mask_next;
            o_valid_reg    <= load || (o_valid_reg && !corner.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_x_reg[count_idx] <= cmd_data.x;
        end
        if (bl_we)
        begin
            bl_x_reg <= cmd_data.x;
            bl_y_reg <= cmd_data.y;
        end
        if (load)
        begin
            o_idx_reg  <= n_idx;
            o_kind_reg <= n_kind;
            o_x_reg    <= n_x;
            o_y_reg    <= n_y;
            o_err_reg  <= n_err;
            o_last_reg <= n_last;
        end
    end

    assign corner.valid       = o_valid_reg;
    assign corner.rect_index  = o_idx_reg;
    assign corner.corner_kind = o_kind_reg;
    assign corner.corner_x    = o_x_reg;
    assign corner.corner_y    = o_y_reg;
    assign corner.error_flag  = o_err_reg;
    assign corner.last_of_run = o_last_reg;

    a_drain_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
        draining |-> !cmd_ready)
        else $error("command popped while bottom-left results pending");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(edge_valid_reg) <= rect_count_reg)
        else $error("more open edges than rectangles");

    a_bl_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !cmd_data.clear && cmd_data.kind == CORNER_BL |=>
        (mask_reg & edge_valid_reg) == '0)
        else $error("matched left edge still valid");

endmodule

FILE: hdl/key_color_rectangle_corner_finder_top.sv
`timescale 1ns / 1ps
// Top level: configuration registers, pixel front end, command queue and rectangle table.
// A pixel is registered into the evaluation stage when accepted and classified there; its word then
// passes the queue and the result register, a bottom-left corner only after storing its matches.
// Throughput: one pixel per cycle unless the queue stalls; one flag row read and write per pixel;
// the table gives at most one word per cycle; a bottom-left corner with m matches gives m words.
// Reset: counters, rectangle table and queue clear, configuration returns to its defaults;
// the key flag row memory is not cleared, so no clearing pass is needed.
module key_color_rectangle_corner_finder_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [kcrcf_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [kcrcf_pkg::CFG_DW-1:0]  cfg_data,
    kcrcf_pixel_if.sink                   pixel,
    kcrcf_corner_if.source                corner
);
    import kcrcf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic q_push_valid;
    logic q_push_ready;
    cmd_t q_push_data;
    logic q_pop_valid;
    logic q_pop_ready;
    cmd_t q_pop_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_BLUE:    cfg_next.key_blue    = cfg_data[CW-1:0];
                REG_KEY_GREEN:   cfg_next.key_green   = cfg_data[CW-1:0];
                REG_KEY_RED:     cfg_next.key_red     = cfg_data[CW-1:0];
                REG_IMAGE_WIDTH: cfg_next.image_width = cfg_data[WW-1:0];
                REG_SCAN_WIDTH:  cfg_next.scan_width  = cfg_data[XW-1:0];
                REG_SCAN_HEIGHT: cfg_next.scan_height = cfg_data[YW-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_blue    <= KEY_BLUE_RST;
            cfg_reg.key_green   <= KEY_GREEN_RST;
            cfg_reg.key_red     <= KEY_RED_RST;
            cfg_reg.image_width <= IMAGE_WIDTH_RST;
            cfg_reg.scan_width  <= SCAN_WIDTH_RST;
            cfg_reg.scan_height <= SCAN_HEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    kcrcf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pixel      (pixel),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    kcrcf_fifo u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    kcrcf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_pop_valid),
        .cmd_ready (q_pop_ready),
        .cmd_data  (q_pop_data),
        .corner    (corner)
    );

endmodule
